// ----- hdl/search_result_hash_table_top_assert.svh -----
// Assertion macros for the search result hash table top level.
// Clocked on i_clk, disabled while i_rst_n is low; no other dependencies.
`ifndef SEARCH_RESULT_HASH_TABLE_TOP_ASSERT_SVH
`define SEARCH_RESULT_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SRHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/srht_pkg.sv -----
// Shared types and constants for the search result hash table.
// No dependencies; imported by controller, datapath and top level.
`timescale 1ns / 1ps

package srht_pkg;

    localparam int TABLE_ENTRIES = 4096;  // power of two, 16 .. 1048576
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ACT_PROBE  = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_NEWGEN = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef struct packed {
        logic [63:0] tag;
        logic [7:0]  gen;
        logic [7:0]  target;
        logic [7:0]  origin;
        logic [1:0]  bound;
        logic [6:0]  depth;
        logic [15:0] score;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;   // capture item, read its slot
        logic decide;   // compare, write slot, load result
        logic sweep;    // zero one slot
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic is_clear;
        logic out_valid;
    } t_sts;

endpackage

// ----- hdl/srht_if.sv -----
// Valid/ready channel interfaces for request and response items.
// No dependencies.
`timescale 1ns / 1ps

interface srht_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [63:0]       position_key;
    logic signed [15:0] entry_score;
    logic [6:0]        entry_depth;
    logic [1:0]        bound_kind;
    logic [7:0]        move_origin;
    logic [7:0]        move_target;

    modport source (
        output valid, action, position_key, entry_score, entry_depth,
               bound_kind, move_origin, move_target,
        input  ready
    );
    modport sink (
        input  valid, action, position_key, entry_score, entry_depth,
               bound_kind, move_origin, move_target,
        output ready
    );
endinterface

interface srht_rsp_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              written;
    logic signed [15:0] found_score;
    logic [6:0]        found_depth;
    logic [1:0]        found_bound;
    logic [7:0]        found_origin;
    logic [7:0]        found_target;

    modport source (
        output valid, hit, written, found_score, found_depth, found_bound,
               found_origin, found_target,
        input  ready
    );
    modport sink (
        input  valid, hit, written, found_score, found_depth, found_bound,
               found_origin, found_target,
        output ready
    );
endinterface

// ----- hdl/srht_ctrl.sv -----
// Controller FSM: clearing sweep, accept, decide.
// Depends on srht_pkg (t_cmd, t_sts).
`timescale 1ns / 1ps

module srht_ctrl
    import srht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECIDE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.in_ready = (r_state == ST_IDLE);
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.decide   = (r_state == ST_DECIDE) && (!i_sts.out_valid || i_out_ready);
        o_cmd.sweep    = (r_state == ST_SWEEP);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (i_sts.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (o_cmd.decide) n_state = i_sts.is_clear ? ST_SWEEP : ST_IDLE;
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/srht_datapath.sv -----
// Datapath: slot memory, generation counter, replace logic, result register.
// Depends on srht_pkg (t_entry, t_action, t_cmd, t_sts, sizes).
`timescale 1ns / 1ps

module srht_datapath
    import srht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_action,
    input  logic [63:0]        i_key,
    input  logic [15:0]        i_score,
    input  logic [6:0]         i_depth,
    input  logic [1:0]         i_bound,
    input  logic [7:0]         i_origin,
    input  logic [7:0]         i_target,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_hit,
    output logic               o_written,
    output logic signed [15:0] o_found_score,
    output logic [6:0]         o_found_depth,
    output logic [1:0]         o_found_bound,
    output logic [7:0]         o_found_origin,
    output logic [7:0]         o_found_target
);

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;

    // captured item
    t_action     r_action;
    logic [63:0] r_key;
    logic [15:0] r_score;
    logic [6:0]  r_depth;
    logic [1:0]  r_bound;
    logic [7:0]  r_origin;
    logic [7:0]  r_target;

    logic [7:0]       r_gen;
    logic [IDX_W-1:0] r_sweep_addr;

    logic        r_out_valid;
    logic        r_hit;
    logic        r_written;
    logic [15:0] r_f_score;
    logic [6:0]  r_f_depth;
    logic [1:0]  r_f_bound;
    logic [7:0]  r_f_origin;
    logic [7:0]  r_f_target;

    logic             w_hit;
    logic             w_replace;
    logic             w_store;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_new;
    t_entry           w_wdata;

    assign w_hit     = (r_action == ACT_PROBE) && (r_rd.tag == r_key);
    assign w_replace = (r_rd.tag == 64'd0) || (r_rd.tag == r_key) ||
                       (r_rd.gen != r_gen) || (r_rd.depth <= r_depth);
    assign w_store   = (r_action == ACT_STORE) && w_replace;

    always_comb begin
        w_new.tag    = r_key;
        w_new.gen    = r_gen;
        w_new.target = r_target;
        w_new.origin = r_origin;
        w_new.bound  = r_bound;
        w_new.depth  = r_depth;
        w_new.score  = r_score;
    end

    assign w_we    = i_cmd.sweep || (i_cmd.decide && w_store);
    assign w_waddr = i_cmd.sweep ? r_sweep_addr : r_key[IDX_W-1:0];
    assign w_wdata = i_cmd.sweep ? t_entry'('0) : w_new;

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_cmd.accept) r_rd <= r_mem[i_key[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= t_action'(i_action);
            r_key    <= i_key;
            r_score  <= i_score;
            r_depth  <= i_depth;
            r_bound  <= i_bound;
            r_origin <= i_origin;
            r_target <= i_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen        <= 8'd0;
            r_sweep_addr <= '0;
        end else begin
            if (i_cmd.sweep) r_sweep_addr <= r_sweep_addr + 1'b1;
            if (i_cmd.decide) begin
                case (r_action)
                    ACT_NEWGEN: r_gen <= r_gen + 8'd1;
                    ACT_CLEAR:  r_gen <= 8'd0;
                    default:    r_gen <= r_gen;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_hit      <= w_hit;
            r_written  <= w_store;
            r_f_score  <= w_hit ? r_rd.score  : 16'd0;
            r_f_depth  <= w_hit ? r_rd.depth  : 7'd0;
            r_f_bound  <= w_hit ? r_rd.bound  : 2'd0;
            r_f_origin <= w_hit ? r_rd.origin : 8'd0;
            r_f_target <= w_hit ? r_rd.target : 8'd0;
        end
    end

    assign o_sts.sweep_last = (r_sweep_addr == IDX_W'(TABLE_ENTRIES - 1));
    assign o_sts.is_clear   = (r_action == ACT_CLEAR);
    assign o_sts.out_valid  = r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_written      = r_written;
    assign o_found_score  = $signed(r_f_score);
    assign o_found_depth  = r_f_depth;
    assign o_found_bound  = r_f_bound;
    assign o_found_origin = r_f_origin;
    assign o_found_target = r_f_target;

endmodule

// ----- hdl/search_result_hash_table_top.sv -----
// Top level of the search result hash table: controller plus datapath.
// Depends on srht_pkg, srht_if, srht_ctrl, srht_datapath and the assert header.
//
//   channel  direction  modport  carries
//   i_req    in         sink     action, position_key, entry fields
//   o_rsp    out        source   hit, written, found fields
//
// Probe, store and new-generation items pass through accept, which reads the
// slot into a register, then decide, which compares, writes back and loads the
// result register. The registered slot read ahead of the write keeps decide
// apart from accept. A clear item is accepted, then its result is loaded, then
// a sweep zeroes one slot per cycle while i_req.ready stays low. After reset
// the same sweep zeroes every slot before the first item is taken. A stalled
// o_rsp holds the decide step; the next item is still accepted while a
// finished result waits.
`timescale 1ns / 1ps

`include "search_result_hash_table_top_assert.svh"

module search_result_hash_table_top
    import srht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    srht_req_if.sink   i_req,
    srht_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    srht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // request ready comes straight from the controller state
    assign i_req.ready = w_cmd.in_ready;

    srht_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_req.action),
        .i_key          (i_req.position_key),
        .i_score        (i_req.entry_score),
        .i_depth        (i_req.entry_depth),
        .i_bound        (i_req.bound_kind),
        .i_origin       (i_req.move_origin),
        .i_target       (i_req.move_target),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_hit          (o_rsp.hit),
        .o_written      (o_rsp.written),
        .o_found_score  (o_rsp.found_score),
        .o_found_depth  (o_rsp.found_depth),
        .o_found_bound  (o_rsp.found_bound),
        .o_found_origin (o_rsp.found_origin),
        .o_found_target (o_rsp.found_target)
    );

    // nothing is taken while the table is being zeroed
    `SRHT_ASSERT_IMP(a_no_accept_in_sweep, w_cmd.sweep, !i_req.ready, "item taken during sweep")
    // a decide never overwrites a result that is still pending
    `SRHT_ASSERT_IMP(a_no_result_overrun, w_cmd.decide, !o_rsp.valid || o_rsp.ready, "result overrun")
    // one item at a time: the cycle after an accept is the decide phase
    `SRHT_ASSERT_NEXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready, "second item in flight")
    // the last swept slot hands over to idle
    `SRHT_ASSERT_NEXT(a_sweep_ends, w_cmd.sweep && w_sts.sweep_last, i_req.ready, "sweep did not end")
    // a result shows up only from a decide step
    `SRHT_ASSERT_IMP(a_result_source, $rose(o_rsp.valid), $past(w_cmd.decide), "spurious result")

endmodule
